### hdl/cxpc_pkg.sv
// Shared types and constants for the chained XOR packet cipher.
`default_nettype none

package cxpc_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned HDR_POS_W = 3;
   localparam int unsigned CSR_IDX_W = 2;

   // Header layout: bytes 0..3 pass through, byte 3 is the key, byte 4 is the checksum.
   localparam logic [HDR_POS_W-1:0] HDR_KEY_POS   = 3'd3;
   localparam logic [HDR_POS_W-1:0] HDR_CHECK_POS = 3'd4;
   localparam logic [HDR_POS_W-1:0] HDR_PAYLOAD   = 3'd5;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_DECODE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_KEY   = 2'd1;

   typedef struct packed {
      logic              decode_mode;
      logic [BYTE_W-1:0] outer_key;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first_byte;
      logic              last_byte;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_out;
      logic              checksum_ok;
   } rsp_item_type;

endpackage

`default_nettype wire

### hdl/cxpc_req_if.sv
// Input byte channel: valid/ready handshake with one packet byte per transfer.
`default_nettype none

interface cxpc_req_if;
   import cxpc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              first_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output first_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                   output ready);
endinterface

`default_nettype wire

### hdl/cxpc_rsp_if.sv
// Result byte channel: valid/ready handshake with one output byte per transfer.
`default_nettype none

interface cxpc_rsp_if;
   import cxpc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_out;
   logic              checksum_ok;

   modport source (output valid, output out_byte, output last_out, output checksum_ok,
                   input ready);
   modport sink   (input valid, input out_byte, input last_out, input checksum_ok,
                   output ready);
endinterface

`default_nettype wire

### hdl/cxpc_csr_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface cxpc_csr_if;
   import cxpc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/chained_xor_packet_cipher_unit.sv
// A byte accepted into the input register passes through the cipher into the result register
// when that is free, and is offered on the result channel from there.
// Throughput: one byte per cycle; the input register and the result register each advance
// whenever the stage after them is empty or is being drained in the same cycle.
// Reset clears the configuration registers (encode mode, fixed key zero), all packet
// chaining state and both valid flags; the block accepts bytes in the cycle after reset.
`default_nettype none

module chained_xor_packet_cipher_unit (
   input  logic        clock,
   input  logic        reset,
   cxpc_req_if.sink    req_chan,
   cxpc_rsp_if.source  rsp_chan,
   cxpc_csr_if.sink    csr_chan
);
   import cxpc_pkg::*;

   cfg_type      cfg;
   req_item_type in_item_ff,  in_item_in;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         out_free, stage_fire, req_fire;

   cxpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   cxpc_cipher u_cipher (
      .clock   (clock),
      .reset   (reset),
      .advance (stage_fire),
      .cfg     (cfg),
      .item    (in_item_ff),
      .result  (rsp_item_in)
   );

   // The result register can take a new byte when it is empty or its transfer completes now.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign stage_fire     = in_valid_ff && out_free;
   assign req_chan.ready = !reset && (!in_valid_ff || out_free);
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_item_in.data_byte  = req_chan.data_byte;
      in_item_in.first_byte = req_chan.first_byte;
      in_item_in.last_byte  = req_chan.last_byte;
      in_valid_in  = req_fire ? 1'b1 : (stage_fire ? 1'b0 : in_valid_ff);
      rsp_valid_in = stage_fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= in_item_in;
      end
      if (stage_fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = rsp_item_ff.out_byte;
   assign rsp_chan.last_out    = rsp_item_ff.last_out;
   assign rsp_chan.checksum_ok = rsp_item_ff.checksum_ok;

endmodule

`default_nettype wire

### hdl/cxpc_csr.sv
// Configuration registers: cipher direction and fixed key.
`default_nettype none

module cxpc_csr (
   input  logic              clock,
   input  logic              reset,
   cxpc_csr_if.sink          csr_chan,
   output cxpc_pkg::cfg_type cfg
);
   import cxpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_DECODE_MODE: cfg_in.decode_mode = csr_chan.data[0];
            CSR_OUTER_KEY:   cfg_in.outer_key   = csr_chan.data;
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hdl/cxpc_cipher.sv
// Per-packet chaining state and the two-stage XOR cipher for one byte.
`default_nettype none

module cxpc_cipher (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  cxpc_pkg::cfg_type      cfg,
   input  cxpc_pkg::req_item_type item,
   output cxpc_pkg::rsp_item_type result
);
   import cxpc_pkg::*;

   logic [HDR_POS_W-1:0] hdr_pos_ff,  hdr_pos_in;
   logic [BYTE_W-1:0]    pos_term_ff, pos_term_in;
   logic [BYTE_W-1:0]    inner_ff,    inner_in;
   logic [BYTE_W-1:0]    outer_ff,    outer_in;
   logic [BYTE_W-1:0]    key_ff,      key_in;
   logic [BYTE_W-1:0]    sum_ff,      sum_in;
   logic [BYTE_W-1:0]    check_ff,    check_in;

   logic [HDR_POS_W-1:0] cur_pos;
   logic [BYTE_W-1:0]    cur_term, cur_inner, cur_outer, cur_key, cur_sum, cur_check;
   logic [BYTE_W-1:0]    k, inner_pad, outer_pad, mid, res, plain;

   // A first byte starts from a cleared packet state.
   always_comb begin
      cur_pos   = item.first_byte ? '0 : hdr_pos_ff;
      cur_term  = item.first_byte ? '0 : pos_term_ff;
      cur_inner = item.first_byte ? '0 : inner_ff;
      cur_outer = item.first_byte ? '0 : outer_ff;
      cur_key   = item.first_byte ? '0 : key_ff;
      cur_sum   = item.first_byte ? '0 : sum_ff;
      cur_check = item.first_byte ? '0 : check_ff;
   end

   always_comb begin
      k         = cur_term + 8'd1;
      inner_pad = cur_inner + cur_key + k;
      outer_pad = cur_outer + cfg.outer_key + k;
      mid       = item.data_byte ^ (cfg.decode_mode ? outer_pad : inner_pad);
      res       = mid ^ (cfg.decode_mode ? inner_pad : outer_pad);
      plain     = cfg.decode_mode ? res : item.data_byte;

      hdr_pos_in  = cur_pos;
      pos_term_in = cur_term;
      inner_in    = cur_inner;
      outer_in    = cur_outer;
      key_in      = cur_key;
      sum_in      = cur_sum;
      check_in    = cur_check;
      result.out_byte    = item.data_byte;
      result.last_out    = item.last_byte;
      result.checksum_ok = 1'b0;

      if (cur_pos < HDR_CHECK_POS) begin
         if (cur_pos == HDR_KEY_POS) begin
            key_in = item.data_byte;
         end
         hdr_pos_in = cur_pos + 3'd1;
      end else begin
         pos_term_in     = k;
         result.out_byte = res;
         inner_in        = mid;
         outer_in        = cfg.decode_mode ? item.data_byte : res;
         if (cur_pos == HDR_CHECK_POS) begin
            check_in   = plain;
            hdr_pos_in = HDR_PAYLOAD;
         end else begin
            sum_in = cur_sum + plain;
         end
         result.checksum_ok = item.last_byte && cfg.decode_mode && (sum_in == check_in);
      end

      // The byte after a last byte opens a new packet.
      if (item.last_byte) begin
         hdr_pos_in  = '0;
         pos_term_in = '0;
         inner_in    = '0;
         outer_in    = '0;
         key_in      = '0;
         sum_in      = '0;
         check_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff  <= '0;
         pos_term_ff <= '0;
         inner_ff    <= '0;
         outer_ff    <= '0;
         key_ff      <= '0;
         sum_ff      <= '0;
         check_ff    <= '0;
      end else if (advance) begin
         hdr_pos_ff  <= hdr_pos_in;
         pos_term_ff <= pos_term_in;
         inner_ff    <= inner_in;
         outer_ff    <= outer_in;
         key_ff      <= key_in;
         sum_ff      <= sum_in;
         check_ff    <= check_in;
      end
   end

endmodule

`default_nettype wire

### tb/chained_xor_packet_cipher_unit_tb.sv
// Self-checking testbench for the chained XOR packet cipher with random traffic and stalls.
`timescale 1ns / 100ps

module chained_xor_packet_cipher_unit_tb;
   import cxpc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned NUM_PHASES  = 7;
   localparam int unsigned PHASE_ITEMS = 275;
   localparam int unsigned PRINT_CAP   = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   cxpc_req_if req_if ();
   cxpc_rsp_if rsp_if ();
   cxpc_csr_if csr_if ();

   chained_xor_packet_cipher_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Testbench-side copies of every channel input of the block, known from time zero.
   logic                 drv_valid  = 1'b0;
   logic [BYTE_W-1:0]    drv_data   = '0;
   logic                 drv_first  = 1'b0;
   logic                 drv_last   = 1'b0;
   logic                 rsp_accept = 1'b0;
   logic                 cfg_valid  = 1'b0;
   logic [CSR_IDX_W-1:0] cfg_index  = CSR_DECODE_MODE;
   logic [BYTE_W-1:0]    cfg_data   = '0;

   assign req_if.valid      = drv_valid;
   assign req_if.data_byte  = drv_data;
   assign req_if.first_byte = drv_first;
   assign req_if.last_byte  = drv_last;
   assign rsp_if.ready      = rsp_accept;
   assign csr_if.valid      = cfg_valid;
   assign csr_if.index      = cfg_index;
   assign csr_if.data       = cfg_data;

   req_item_type byte_stream_q[$];
   rsp_item_type predicted_bytes_q[$];
   logic [BYTE_W-1:0] pkt_buf[$];

   int unsigned cycle_count  = 0;
   int unsigned error_count  = 0;
   int unsigned hold_left    = 0;
   bit          hold_trigger = 1'b0;
   bit          hold_used    = 1'b0;
   bit          idle_on      = 1'b1;

   // Shadow of the block's configuration and packet state.
   cfg_type              shadow_cfg = '0;
   logic [HDR_POS_W-1:0] hdr_pos     = '0;
   logic [BYTE_W-1:0]    pos_k       = '0;
   logic [BYTE_W-1:0]    inner_chain = '0;
   logic [BYTE_W-1:0]    outer_chain = '0;
   logic [BYTE_W-1:0]    pkt_key     = '0;
   logic [BYTE_W-1:0]    plain_sum   = '0;
   logic [BYTE_W-1:0]    rx_checksum = '0;

   function automatic void clear_packet_state();
      hdr_pos     = '0;
      pos_k       = '0;
      inner_chain = '0;
      outer_chain = '0;
      pkt_key     = '0;
      plain_sum   = '0;
      rx_checksum = '0;
   endfunction

   function automatic rsp_item_type cipher_byte(input req_item_type item);
      rsp_item_type      res;
      logic [BYTE_W-1:0] k;
      logic [BYTE_W-1:0] inner_mask;
      logic [BYTE_W-1:0] outer_mask;
      logic [BYTE_W-1:0] p;
      logic [BYTE_W-1:0] plain;
      res.last_out    = item.last_byte;
      res.checksum_ok = 1'b0;
      if (item.first_byte) clear_packet_state();
      if (hdr_pos < HDR_CHECK_POS) begin
         res.out_byte = item.data_byte;
         if (hdr_pos == HDR_KEY_POS) pkt_key = item.data_byte;
         hdr_pos = hdr_pos + 3'd1;
      end else begin
         k     = pos_k + 8'd1;
         pos_k = k;
         if (shadow_cfg.decode_mode) begin
            outer_mask   = outer_chain + shadow_cfg.outer_key + k;
            p            = item.data_byte ^ outer_mask;
            inner_mask   = inner_chain + pkt_key + k;
            res.out_byte = p ^ inner_mask;
            outer_chain  = item.data_byte;
            inner_chain  = p;
            plain        = res.out_byte;
         end else begin
            inner_mask   = inner_chain + pkt_key + k;
            p            = item.data_byte ^ inner_mask;
            outer_mask   = outer_chain + shadow_cfg.outer_key + k;
            res.out_byte = p ^ outer_mask;
            inner_chain  = p;
            outer_chain  = res.out_byte;
            plain        = item.data_byte;
         end
         if (hdr_pos == HDR_CHECK_POS) begin
            rx_checksum = plain;
            hdr_pos     = HDR_PAYLOAD;
         end else begin
            plain_sum = plain_sum + plain;
         end
         if (item.last_byte && shadow_cfg.decode_mode && plain_sum == rx_checksum)
            res.checksum_ok = 1'b1;
      end
      if (item.last_byte) clear_packet_state();
      return res;
   endfunction

   // Turns the plain packet in pkt_buf into what a peer with the same key would send.
   function automatic void encipher_pkt_buf(input logic [BYTE_W-1:0] shared_key);
      logic [BYTE_W-1:0] k;
      logic [BYTE_W-1:0] inner_mask;
      logic [BYTE_W-1:0] outer_mask;
      logic [BYTE_W-1:0] p;
      logic [BYTE_W-1:0] pi;
      logic [BYTE_W-1:0] po;
      pi = '0;
      po = '0;
      for (int i = 4; i < pkt_buf.size(); i++) begin
         k          = 8'(i - 3);
         inner_mask = pi + pkt_buf[3] + k;
         p          = pkt_buf[i] ^ inner_mask;
         outer_mask = po + shared_key + k;
         pkt_buf[i] = p ^ outer_mask;
         pi         = p;
         po         = pkt_buf[i];
      end
   endfunction

   // Builds a well-formed plain packet, then ciphers it when the block is deciphering.
   function automatic void build_packet(input int unsigned payload_len);
      logic [BYTE_W-1:0] sum;
      logic [15:0]       len16;
      sum   = '0;
      len16 = 16'(payload_len);
      pkt_buf.delete();
      pkt_buf.push_back(8'($urandom_range(0, 255)));
      pkt_buf.push_back(len16[7:0]);
      pkt_buf.push_back(len16[15:8]);
      pkt_buf.push_back(8'($urandom_range(0, 255)));
      pkt_buf.push_back(8'h00);
      for (int i = 0; i < payload_len; i++) begin
         pkt_buf.push_back(8'($urandom_range(0, 255)));
         sum = sum + pkt_buf[pkt_buf.size() - 1];
      end
      pkt_buf[4] = sum;
      if (shadow_cfg.decode_mode) encipher_pkt_buf(shadow_cfg.outer_key);
   endfunction

   function automatic void push_bytes(input int unsigned start, input int unsigned count,
                                      input bit mark_first, input bit mark_last);
      req_item_type item;
      for (int i = 0; i < count; i++) begin
         item.data_byte  = pkt_buf[start + i];
         item.first_byte = mark_first && (i == 0);
         item.last_byte  = mark_last && (i == count - 1);
         byte_stream_q.push_back(item);
      end
   endfunction

   function automatic int unsigned queue_random_traffic(input int unsigned n_items);
      int unsigned queued;
      int unsigned pick;
      int unsigned plen;
      int unsigned keep;
      int unsigned hit;
      req_item_type item;
      queued = 0;
      while (queued < n_items) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            plen = ($urandom_range(0, 39) == 0) ? $urandom_range(255, 300)
                                                : $urandom_range(0, 12);
            build_packet(plen);
            if (pick == 13) begin
               hit = $urandom_range(0, pkt_buf.size() - 1);
               pkt_buf[hit] = pkt_buf[hit] ^ (8'h01 << $urandom_range(0, 7));
            end
            push_bytes(0, pkt_buf.size(), $urandom_range(0, 3) != 0, 1'b1);
            queued += pkt_buf.size();
         end else if (pick < 17) begin
            // Packet cut short, possibly inside the header.
            build_packet($urandom_range(0, 4));
            keep = $urandom_range(1, pkt_buf.size());
            push_bytes(0, keep, 1'b1, 1'b1);
            queued += keep;
         end else begin
            keep = $urandom_range(1, 8);
            for (int i = 0; i < keep; i++) begin
               item.data_byte  = 8'($urandom_range(0, 255));
               item.first_byte = ($urandom_range(0, 5) == 0);
               item.last_byte  = ($urandom_range(0, 5) == 0);
               byte_stream_q.push_back(item);
            end
            queued += keep;
         end
      end
      return queued;
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_CAP)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (byte_stream_q.size() != 0 || drv_valid || predicted_bytes_q.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      @(posedge clock);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      cfg_valid <= 1'b0;
      if (idx == CSR_DECODE_MODE) shadow_cfg.decode_mode = val[0];
      else shadow_cfg.outer_key = val;
   endtask

   task automatic set_cipher_mode(input logic decode, input logic [BYTE_W-1:0] key);
      write_csr(CSR_DECODE_MODE, {7'd0, decode});
      write_csr(CSR_OUTER_KEY, key);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Driver: predicts each accepted byte and offers the next one from the stream.
   always @(posedge clock) begin : byte_driver
      int unsigned  gap_left;
      req_item_type cur;
      req_item_type nxt;
      if (reset) begin
         gap_left = 0;
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_if.ready) begin
            cur.data_byte  = drv_data;
            cur.first_byte = drv_first;
            cur.last_byte  = drv_last;
            predicted_bytes_q.push_back(cipher_byte(cur));
         end
         if (!drv_valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               drv_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(0, 5);
               drv_valid <= 1'b0;
            end else if (byte_stream_q.size() != 0) begin
               nxt = byte_stream_q.pop_front();
               drv_valid <= 1'b1;
               drv_data  <= nxt.data_byte;
               drv_first <= nxt.first_byte;
               drv_last  <= nxt.last_byte;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, so the block fills and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_trigger && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: checks each result transfer against the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      int unsigned  stall_left;
      rsp_item_type exp;
      if (reset) begin
         stall_left = 0;
         rsp_accept <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_accept) begin
            if (predicted_bytes_q.size() == 0) begin
               report_mismatch($sformatf("result %02h with nothing predicted",
                                         rsp_if.out_byte));
            end else begin
               exp = predicted_bytes_q.pop_front();
               if (rsp_if.out_byte !== exp.out_byte)
                  report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                            rsp_if.out_byte, exp.out_byte));
               if (rsp_if.last_out !== exp.last_out)
                  report_mismatch($sformatf("last_out %b, predicted %b",
                                            rsp_if.last_out, exp.last_out));
               if (rsp_if.checksum_ok !== exp.checksum_ok)
                  report_mismatch($sformatf("checksum_ok %b, predicted %b",
                                            rsp_if.checksum_ok, exp.checksum_ok));
            end
         end
         if (hold_left > 0) begin
            rsp_accept <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_accept <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_accept <= 1'b0;
         end else begin
            rsp_accept <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic              mode;
      logic [BYTE_W-1:0] key;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: encode with a zero key. Extreme bytes in a full packet.
      pkt_buf = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00};
      push_bytes(0, 6, 1'b1, 1'b1);
      // Packet that ends inside the header.
      pkt_buf = '{8'hFF, 8'hFF, 8'hFF};
      push_bytes(0, 3, 1'b1, 1'b1);
      // Next packet starts without a first flag and ends on its checksum byte.
      pkt_buf = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
      push_bytes(0, 5, 1'b0, 1'b1);
      // Settings change in the middle of a packet.
      build_packet(1);
      push_bytes(0, 5, 1'b1, 1'b0);
      wait_drained();
      set_cipher_mode(1'b1, 8'hFF);
      push_bytes(5, 1, 1'b0, 1'b1);
      // A peer-enciphered packet whose checksum matches.
      build_packet(1);
      push_bytes(0, pkt_buf.size(), 1'b1, 1'b1);
      wait_drained();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph < 4) begin
            mode = ph[0];
            key  = (ph < 2) ? 8'h00 : 8'hFF;
         end else begin
            mode = (ph != 5);
            key  = 8'($urandom_range(0, 255));
         end
         set_cipher_mode(mode, key);
         idle_on = (ph != NUM_PHASES - 1);
         void'(queue_random_traffic(PHASE_ITEMS));
         if (ph == 2) hold_trigger = 1'b1;
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### sim.f
hdl/cxpc_pkg.sv
hdl/cxpc_req_if.sv
hdl/cxpc_rsp_if.sv
hdl/cxpc_csr_if.sv
hdl/cxpc_csr.sv
hdl/cxpc_cipher.sv
hdl/chained_xor_packet_cipher_unit.sv
tb/chained_xor_packet_cipher_unit_tb.sv
